// File: sv/vasdc_pkg.sv
package vasdc_pkg;

  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = 48;
  localparam int HALF_W = ACC_W / 2;
  localparam int WIDE_W = 2 * ACC_W;
  localparam int QUOT_W = 60;
  localparam int ROOT_W = QUOT_W / 2;
  localparam int CNT_W  = 6;

  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(3);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUOT_W);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W);

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_DOT = 2'd2,
    MODE_COS = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_ACC,
    ST_MUL_P,
    ST_MUL_D,
    ST_DIV,
    ST_SQRT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             load;
    logic             prod;
    logic             acc;
    logic             mul;
    logic             mul_dot;
    logic             div;
    logic             sqrt;
    logic             emit;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    mode_t held_mode;
    logic  last;
    logic  norm_zero;
    logic  out_free;
  } stat_t;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [PROD_W-1:0] p
  );
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(acc) + (ACC_W+1)'(p);
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

endpackage

// File: sv/vasdc_ctrl.sv
module vasdc_ctrl import vasdc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = '0;
    cmd        = '0;
    cmd.cnt    = cnt;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd.prod = 1'b1;
        if (stat.held_mode == MODE_ADD || stat.held_mode == MODE_SUB) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (!stat.last) begin
          state_next = ST_IDLE;
        end else if (stat.held_mode == MODE_DOT) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        if (stat.norm_zero) begin
          state_next = ST_EMIT;
        end else begin
          cmd.mul = 1'b1;
          if (cnt == MUL_LAST) begin
            state_next = ST_MUL_D;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      ST_MUL_D: begin
        cmd.mul     = 1'b1;
        cmd.mul_dot = 1'b1;
        if (cnt == MUL_LAST) begin
          state_next = ST_DIV;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = ST_SQRT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SQRT: begin
        cmd.sqrt = 1'b1;
        if (cnt == SQRT_LAST) begin
          state_next = ST_EMIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/vasdc_dp.sv
module vasdc_dp import vasdc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic [1:0]               mode,
  input  logic signed [ELEM_W-1:0] a_value,
  input  logic signed [ELEM_W-1:0] b_value,
  input  logic                     last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [ACC_W-1:0]  value,
  output logic                     status,
  output logic                     end_of_run
);

  mode_t                     held_mode;
  logic                      in_vector;
  logic signed [ELEM_W-1:0]  a_r, b_r;
  logic                      last_r;
  logic signed [PROD_W-1:0]  pab, paa, pbb;
  logic signed [ELEM_W:0]    elem_res;
  logic signed [ACC_W-1:0]   cross_sum, first_norm_sum, second_norm_sum;
  logic [WIDE_W-1:0]         mul_acc, p_reg, rem, rem2;
  logic                      clamp;
  logic [QUOT_W-1:0]         quot, sq;
  logic [ROOT_W-1:0]         sroot;
  logic [ROOT_W+1:0]         srem, r2, trial;
  logic [ACC_W-1:0]          abs_dot, mx, my;
  logic [HALF_W-1:0]         xh, yh;
  logic [ACC_W-1:0]          part;
  logic [WIDE_W-1:0]         part_sh;
  logic [ROOT_W:0]           cos_mag;
  logic signed [ACC_W-1:0]   cos_val, res_val;
  logic                      res_stat, res_end;

  assign abs_dot = cross_sum[ACC_W-1] ? ACC_W'(-cross_sum) : cross_sum;
  assign mx = cmd.mul_dot ? abs_dot : first_norm_sum;
  assign my = cmd.mul_dot ? abs_dot : second_norm_sum;
  assign xh = cmd.cnt[1] ? mx[ACC_W-1:HALF_W] : mx[HALF_W-1:0];
  assign yh = cmd.cnt[0] ? my[ACC_W-1:HALF_W] : my[HALF_W-1:0];
  assign part = xh * yh;

  always_comb begin
    case (cmd.cnt[1:0])
      2'd0:    part_sh = WIDE_W'(part);
      2'd3:    part_sh = WIDE_W'(part) << (2 * HALF_W);
      default: part_sh = WIDE_W'(part) << HALF_W;
    endcase
  end

  assign rem2  = {rem[WIDE_W-2:0], 1'b0};
  assign r2    = {srem[ROOT_W-1:0], sq[QUOT_W-1:QUOT_W-2]};
  assign trial = {sroot, 2'b01};

  assign cos_mag = clamp ? {1'b1, {ROOT_W{1'b0}}} : {1'b0, sroot};
  assign cos_val = cross_sum[ACC_W-1] ? -ACC_W'(cos_mag) : ACC_W'(cos_mag);

  always_comb begin
    res_stat = 1'b0;
    res_end  = 1'b1;
    case (held_mode)
      MODE_ADD, MODE_SUB: begin
        res_val = ACC_W'(elem_res);
        res_end = last_r;
      end
      MODE_DOT: res_val = cross_sum;
      default: begin
        res_stat = stat.norm_zero;
        res_val  = stat.norm_zero ? '0 : cos_val;
      end
    endcase
  end

  assign stat.held_mode = held_mode;
  assign stat.last      = last_r;
  assign stat.norm_zero = (first_norm_sum == '0) || (second_norm_sum == '0);
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_mode       <= MODE_ADD;
      in_vector       <= 1'b0;
      cross_sum       <= '0;
      first_norm_sum  <= '0;
      second_norm_sum <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.load && !in_vector) begin
        held_mode <= mode_t'(mode);
        in_vector <= 1'b1;
      end
      if (cmd.acc) begin
        cross_sum       <= sat_add(cross_sum, pab);
        first_norm_sum  <= sat_add(first_norm_sum, paa);
        second_norm_sum <= sat_add(second_norm_sum, pbb);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (res_end) begin
          in_vector       <= 1'b0;
          cross_sum       <= '0;
          first_norm_sum  <= '0;
          second_norm_sum <= '0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r    <= a_value;
      b_r    <= b_value;
      last_r <= last;
    end
    if (cmd.prod) begin
      pab <= a_r * b_r;
      paa <= a_r * a_r;
      pbb <= b_r * b_r;
      if (held_mode == MODE_ADD) begin
        elem_res <= (ELEM_W+1)'(a_r) + (ELEM_W+1)'(b_r);
      end else begin
        elem_res <= (ELEM_W+1)'(a_r) - (ELEM_W+1)'(b_r);
      end
    end
    if (cmd.mul) begin
      mul_acc <= (cmd.cnt == '0 ? '0 : mul_acc) + part_sh;
      // The product of the norms is complete when the dot square starts.
      if (cmd.mul_dot && cmd.cnt == '0) begin
        p_reg <= mul_acc;
      end
    end
    if (cmd.div) begin
      if (cmd.cnt == '0) begin
        rem   <= mul_acc;
        clamp <= mul_acc >= p_reg;
        quot  <= '0;
      end else if (rem2 >= p_reg) begin
        rem  <= rem2 - p_reg;
        quot <= {quot[QUOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem2;
        quot <= {quot[QUOT_W-2:0], 1'b0};
      end
    end
    if (cmd.sqrt) begin
      if (cmd.cnt == '0) begin
        sq    <= quot;
        sroot <= '0;
        srem  <= '0;
      end else begin
        sq <= {sq[QUOT_W-3:0], 2'b00};
        if (r2 >= trial) begin
          srem  <= r2 - trial;
          sroot <= {sroot[ROOT_W-2:0], 1'b1};
        end else begin
          srem  <= r2;
          sroot <= {sroot[ROOT_W-2:0], 1'b0};
        end
      end
    end
    if (cmd.emit) begin
      value      <= res_val;
      status     <= res_stat;
      end_of_run <= res_end;
    end
  end

endmodule

// File: sv/vector_add_sub_dot_cosine.sv
// Streaming vector unit: add, subtract, dot product and cosine similarity.
// Each input item carries one element pair (a_value, b_value) in signed
// Q8.8, with last marking the final pair. The operation comes from mode on
// the first item of a vector and holds until that vector ends.
// Both channels use valid/ready; an item moves when valid and ready are high.
// Add and subtract return one item per pair.
// Dot product and cosine return one item after the last pair; the dot sum
// is in Q32.16 and cosine is a Q1.30 ratio with status 1 when a magnitude
// is zero. The block handles one pair at a time: an accumulating pair goes
// through register, multiply and saturating add, and an add or subtract
// pair through register, add and output write. After the last pair, cosine
// runs one shared 24x24 multiplier, a bit-serial divider and a bit-serial
// square root.
// Results sit in an output register, so a stalled receiver holds the block
// only when a second result is ready to be written.
// Synchronous reset clears the mode, the accumulators and the output valid.
module vector_add_sub_dot_cosine import vasdc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               mode,
  input  logic signed [ELEM_W-1:0] a_value,
  input  logic signed [ELEM_W-1:0] b_value,
  input  logic                     last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [ACC_W-1:0]  value,
  output logic                     status,
  output logic                     end_of_run
);

  cmd_t  cmd;
  stat_t stat;

  // The sequencer decides what the datapath does each cycle.
  vasdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the accumulators, the cosine units and the output.
  vasdc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .mode       (mode),
    .a_value    (a_value),
    .b_value    (b_value),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .status     (status),
    .end_of_run (end_of_run)
  );

`ifndef SYNTHESIS
  // A flagged cosine always closes its vector.
  a_status_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> end_of_run)
    else $error("status set on a result that does not end a vector");

  // A flagged cosine carries a zero value.
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> value == '0)
    else $error("status set with nonzero value");

  // The block is not ready in the cycle after it takes an item.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted on consecutive cycles");
`endif

endmodule
